>>> hdl/stb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank package
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int SLOTS  = 8;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int TPM_W  = 10;
   localparam int MS_W   = 16;
   localparam int TICK_W = 32;
   localparam int PROD_W = MS_W + TPM_W;

   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_REGISTER = 3'd1;
   localparam logic [2:0] OP_REMOVE   = 3'd2;
   localparam logic [2:0] OP_START    = 3'd3;
   localparam logic [2:0] OP_STOP     = 3'd4;
   localparam logic [2:0] OP_QUERY    = 3'd5;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_ERR  = 1'b1;

   typedef struct packed {
      logic [2:0]      opcode;
      logic [2:0]      slot;
      logic            periodic;
      logic            handler_present;
      logic [MS_W-1:0] period_ms;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] fired_slot;
      logic       status;
      logic       running;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic mul_en;
   } arith_ctl_type;

endpackage

>>> hdl/stb_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank shared arithmetic unit
// One multiplier with a registered product, one adder and one comparator,
// reused by the sequencer for deadline checks and deadline updates.
// ----------------------------------------------------------------------------
module stb_arith (
   input  logic                        clock,
   input  stb_pkg::arith_ctl_type      ctl,
   input  logic [stb_pkg::MS_W-1:0]    mul_a,
   input  logic [stb_pkg::TPM_W-1:0]   mul_b,
   input  logic [stb_pkg::TICK_W-1:0]  base,
   input  logic [stb_pkg::TICK_W-1:0]  now,
   output logic [stb_pkg::TICK_W-1:0]  sum,
   output logic                        due
);
   import stb_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign sum = base + TICK_W'(prod_ff);
   assign due = (now >= base);

endmodule

>>> hdl/soft_timer_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer bank
// Eight timer slots driven by tick, register, remove, start, stop and query
// transactions. A tick reports each due slot as an expiry transaction.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (stb_pkg::req_type)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (stb_pkg::rsp_type)
//   csr      in         csr_wr_en            csr_wr_data (ticks per ms)
//
// A tick scans the deadline of every slot through the shared comparator, then
// steps through the slots up to the last due slot (all SLOTS when none is
// due): a one-shot firing goes to the emit step, a periodic firing multiplies,
// adds and emits, and output stall time adds to the whole.
// Other requests execute and emit; a successful start also multiplies and adds.
// Reset is synchronous and clears the flags, the tick count and the sequencer.
// A stalled output holds the sequencer; req_stall is high while busy.
// ----------------------------------------------------------------------------
module soft_timer_bank_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  stb_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output stb_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [stb_pkg::TPM_W-1:0]   csr_wr_data
);
   import stb_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_SCAN = 7'b0000100,
      S_FIRE = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_ADD  = 7'b0100000,
      S_EMIT = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [TPM_W-1:0]  tpm_ff, tpm_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [SLOTS-1:0]  registered_ff, registered_in;
   logic [SLOTS-1:0]  enabled_ff, enabled_in;
   logic [SLOTS-1:0]  periodic_ff, periodic_in;
   logic [SLOTS-1:0]  due_ff, due_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              status_ff, status_in;
   logic              run_ok_ff, run_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [MS_W-1:0]   period_ff [SLOTS];
   logic [TICK_W-1:0] deadline_ff [SLOTS];

   logic              accept;
   logic              is_tick;
   logic              slot_ok;
   logic              can_load;
   logic              tick_last;
   logic [SLOTS-1:0]  above;
   logic              period_we;
   logic              deadline_we;
   logic [SLOT_W-1:0] wr_slot;
   logic [TICK_W-1:0] sum;
   logic              due;
   logic [MS_W-1:0]   mul_a;
   logic [TICK_W-1:0] base;
   arith_ctl_type     arith_ctl;

   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_tick   = (req_ff.opcode == OP_TICK);
   assign slot_ok   = ({1'b0, req_ff.slot} < 4'(SLOTS));
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign wr_slot   = is_tick ? idx_ff : req_ff.slot;
   assign mul_a     = is_tick ? period_ff[idx_ff] : req_ff.period_ms;
   assign base      = is_tick ? deadline_ff[idx_ff] : now_ff;

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         above[j] = due_ff[j] && (SLOT_W'(j) > idx_ff);
      end
   end
   assign tick_last = ~|above;

   stb_arith u_arith (
      .clock (clock),
      .ctl   (arith_ctl),
      .mul_a (mul_a),
      .mul_b (tpm_ff),
      .base  (base),
      .now   (now_ff),
      .sum   (sum),
      .due   (due)
   );

   always_comb begin
      state_in         = state_ff;
      tpm_in           = csr_wr_en ? csr_wr_data : tpm_ff;
      now_in           = now_ff;
      registered_in    = registered_ff;
      enabled_in       = enabled_ff;
      periodic_in      = periodic_ff;
      due_in           = due_ff;
      idx_in           = idx_ff;
      status_in        = status_ff;
      run_ok_in        = run_ok_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      period_we        = 1'b0;
      deadline_we      = 1'b0;
      arith_ctl.mul_en = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (req_data.opcode == OP_TICK) begin
                  now_in   = now_ff + 1'b1;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            status_in = STATUS_OK;
            run_ok_in = slot_ok && (req_ff.opcode inside {[OP_REGISTER:OP_QUERY]});
            state_in  = S_EMIT;
            if (!slot_ok) begin
               status_in = STATUS_ERR;
            end else begin
               case (req_ff.opcode)
                  OP_REGISTER: begin
                     if (!req_ff.handler_present) begin
                        status_in = STATUS_ERR;
                     end else if (!registered_ff[req_ff.slot]) begin
                        registered_in[req_ff.slot] = 1'b1;
                        periodic_in[req_ff.slot]   = req_ff.periodic;
                        enabled_in[req_ff.slot]    = 1'b0;
                     end
                  end
                  OP_REMOVE: begin
                     if (!registered_ff[req_ff.slot]) begin
                        status_in = STATUS_ERR;
                     end else begin
                        registered_in[req_ff.slot] = 1'b0;
                        enabled_in[req_ff.slot]    = 1'b0;
                     end
                  end
                  OP_START: begin
                     if (req_ff.period_ms == '0 || !registered_ff[req_ff.slot]) begin
                        status_in = STATUS_ERR;
                     end else begin
                        period_we                  = 1'b1;
                        enabled_in[req_ff.slot]    = 1'b1;
                        state_in                   = S_MUL;
                     end
                  end
                  OP_STOP: begin
                     if (!registered_ff[req_ff.slot]) begin
                        status_in = STATUS_ERR;
                     end else begin
                        enabled_in[req_ff.slot] = 1'b0;
                     end
                  end
                  OP_QUERY: begin
                     status_in = STATUS_OK;
                  end
                  default: begin
                     status_in = STATUS_ERR;
                  end
               endcase
            end
         end
         S_SCAN: begin
            due_in[idx_ff] = registered_ff[idx_ff] && enabled_ff[idx_ff] && due;
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               idx_in   = '0;
               state_in = S_FIRE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIRE: begin
            if (due_ff[idx_ff]) begin
               if (periodic_ff[idx_ff]) begin
                  state_in = S_MUL;
               end else begin
                  enabled_in[idx_ff] = 1'b0;
                  state_in           = S_EMIT;
               end
            end else if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_MUL: begin
            arith_ctl.mul_en = 1'b1;
            state_in         = S_ADD;
         end
         S_ADD: begin
            deadline_we = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               if (is_tick) begin
                  rsp_in.kind       = KIND_EXPIRY;
                  rsp_in.fired_slot = 3'(idx_ff);
                  rsp_in.status     = STATUS_OK;
                  rsp_in.running    = enabled_ff[idx_ff];
                  rsp_in.last       = tick_last;
                  if (tick_last) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_FIRE;
                  end
               end else begin
                  rsp_in.kind       = KIND_STATUS;
                  rsp_in.fired_slot = '0;
                  rsp_in.status     = status_ff;
                  rsp_in.running    = run_ok_ff && registered_ff[req_ff.slot]
                                      && enabled_ff[req_ff.slot];
                  rsp_in.last       = 1'b1;
                  state_in          = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tpm_ff        <= TPM_W'(1);
         now_ff        <= '0;
         registered_ff <= '0;
         enabled_ff    <= '0;
         periodic_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tpm_ff        <= tpm_in;
         now_ff        <= now_in;
         registered_ff <= registered_in;
         enabled_ff    <= enabled_in;
         periodic_ff   <= periodic_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      due_ff    <= due_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      run_ok_ff <= run_ok_in;
      rsp_ff    <= rsp_in;
      if (period_we) begin
         period_ff[wr_slot] <= req_ff.period_ms;
      end
      if (deadline_we) begin
         deadline_ff[wr_slot] <= sum;
      end
   end

   a_enabled_needs_registered: assert property (@(posedge clock) disable iff (reset)
      (enabled_ff & ~registered_ff) == '0)
      else $error("A slot is enabled without being registered.");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.kind == KIND_STATUS) |-> rsp_ff.last)
      else $error("A status transaction is not marked last.");

   a_expiry_running_periodic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.kind == KIND_EXPIRY) && rsp_ff.running
      |-> periodic_ff[rsp_ff.fired_slot])
      else $error("A one-shot slot is still running after it fired.");

   a_now_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.opcode != OP_TICK) |=> $stable(now_ff))
      else $error("The tick count moved on a transaction that is not a tick.");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Sends tick, register, remove, start, stop and query transactions to the
// timer bank and keeps its own copy of the slot flags, periods, deadlines and
// tick count. From that copy it works out the status and expiry transactions
// that each request should cause, and checks them in order, field by field.
// The run covers a directed pass over each operation and error case, the
// extreme tick rates, and random traffic under four mixes of sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import stb_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int SETTLE_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int REPORT_LIMIT     = 10;
   localparam int RANDOM_PHASE_OPS = 88;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [TPM_W-1:0] csr_wr_data = '0;

   logic [TPM_W-1:0]  rate_ticks_per_ms;
   logic [TICK_W-1:0] tick_count;
   logic [SLOTS-1:0]  slot_registered;
   logic [SLOTS-1:0]  slot_enabled;
   logic [SLOTS-1:0]  slot_periodic;
   logic [MS_W-1:0]   slot_period [SLOTS];
   logic [TICK_W-1:0] slot_deadline [SLOTS];
   rsp_type           timer_reports [$];
   rsp_type           want_report;

   int idle_pct         = 0;
   int stall_pct        = 0;
   int error_count      = 0;
   int ops_sent         = 0;
   int reports_checked  = 0;
   int expiries_checked = 0;
   int rate_settings    = 0;
   int quiet_cycles     = 0;

   soft_timer_bank_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [TICK_W-1:0] ms_as_ticks(input logic [MS_W-1:0] ms);
      return TICK_W'(ms) * TICK_W'(rate_ticks_per_ms);
   endfunction

   task automatic compute_timer_reports(input req_type op);
      rsp_type rep;
      int      fired;
      int      s;
      rep   = '0;
      fired = 0;
      s     = int'(op.slot);
      if (op.opcode == OP_TICK) begin
         tick_count = tick_count + 1;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_registered[i] && slot_enabled[i] && tick_count >= slot_deadline[i]) begin
               if (slot_periodic[i]) begin
                  slot_deadline[i] = slot_deadline[i] + ms_as_ticks(slot_period[i]);
               end else begin
                  slot_enabled[i] = 1'b0;
               end
               rep.kind       = KIND_EXPIRY;
               rep.fired_slot = SLOT_W'(i);
               rep.status     = STATUS_OK;
               rep.running    = slot_enabled[i];
               rep.last       = 1'b0;
               timer_reports.push_back(rep);
               fired++;
            end
         end
         if (fired > 0) begin
            rep      = timer_reports.pop_back();
            rep.last = 1'b1;
            timer_reports.push_back(rep);
         end
      end else begin
         rep.kind       = KIND_STATUS;
         rep.fired_slot = '0;
         rep.status     = STATUS_OK;
         rep.last       = 1'b1;
         case (op.opcode)
            OP_REGISTER: begin
               if (!op.handler_present) begin
                  rep.status = STATUS_ERR;
               end else if (!slot_registered[s]) begin
                  slot_registered[s] = 1'b1;
                  slot_periodic[s]   = op.periodic;
                  slot_enabled[s]    = 1'b0;
               end
            end
            OP_REMOVE: begin
               if (!slot_registered[s]) begin
                  rep.status = STATUS_ERR;
               end else begin
                  slot_registered[s] = 1'b0;
                  slot_enabled[s]    = 1'b0;
               end
            end
            OP_START: begin
               if (op.period_ms == '0 || !slot_registered[s]) begin
                  rep.status = STATUS_ERR;
               end else begin
                  slot_period[s]   = op.period_ms;
                  slot_deadline[s] = tick_count + ms_as_ticks(op.period_ms);
                  slot_enabled[s]  = 1'b1;
               end
            end
            OP_STOP: begin
               if (!slot_registered[s]) begin
                  rep.status = STATUS_ERR;
               end else begin
                  slot_enabled[s] = 1'b0;
               end
            end
            OP_QUERY: begin
            end
            default: begin
               rep.status = STATUS_ERR;
            end
         endcase
         if (op.opcode > OP_QUERY) begin
            rep.running = 1'b0;
         end else begin
            rep.running = slot_registered[s] && slot_enabled[s];
         end
         timer_reports.push_back(rep);
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t %s: expected kind %0d slot %0d status %0d running %0d last %0d",
                  $time, what, want.kind, want.fired_slot, want.status, want.running,
                  want.last);
         $display("   actual kind %0d slot %0d status %0d running %0d last %0d",
                  got.kind, got.fired_slot, got.status, got.running, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (timer_reports.size() == 0) begin
            note_mismatch("unexpected transaction", '0, rsp_data);
         end else begin
            want_report = timer_reports.pop_front();
            reports_checked++;
            if (want_report.kind == KIND_EXPIRY) begin
               expiries_checked++;
            end
            if (rsp_data.kind !== want_report.kind ||
                rsp_data.fired_slot !== want_report.fired_slot ||
                rsp_data.status !== want_report.status ||
                rsp_data.running !== want_report.running ||
                rsp_data.last !== want_report.last) begin
               note_mismatch("mismatch", want_report, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d reports outstanding",
                  quiet_cycles, timer_reports.size());
         $display("soft_timer_bank_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_op(input logic [2:0] opcode, input int slot,
                                       input logic periodic, input logic handler,
                                       input logic [MS_W-1:0] period_ms);
      req_type op;
      op.opcode          = opcode;
      op.slot            = SLOT_W'(slot);
      op.periodic        = periodic;
      op.handler_present = handler;
      op.period_ms       = period_ms;
      return op;
   endfunction

   function automatic req_type random_timer_op();
      req_type op;
      int      pick;
      int      first;
      pick = $urandom_range(99);
      if (pick < 38) begin
         op.opcode = OP_TICK;
      end else if (pick < 54) begin
         op.opcode = OP_REGISTER;
      end else if (pick < 70) begin
         op.opcode = OP_START;
      end else if (pick < 78) begin
         op.opcode = OP_STOP;
      end else if (pick < 85) begin
         op.opcode = OP_REMOVE;
      end else if (pick < 95) begin
         op.opcode = OP_QUERY;
      end else begin
         op.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      end
      op.slot            = SLOT_W'($urandom_range(SLOTS - 1));
      op.periodic        = 1'($urandom_range(1));
      op.handler_present = ($urandom_range(99) < 88);
      pick = $urandom_range(99);
      if (pick < 8) begin
         op.period_ms = '0;
      end else if (pick < 78) begin
         op.period_ms = MS_W'($urandom_range(6, 1));
      end else begin
         op.period_ms = MS_W'($urandom_range(16'hFFFF));
      end
      // Steer most slot operations toward slots that are actually registered.
      if ((op.opcode == OP_START || op.opcode == OP_STOP || op.opcode == OP_REMOVE) &&
          !slot_registered[op.slot] && $urandom_range(99) < 75) begin
         first = $urandom_range(SLOTS - 1);
         for (int k = 0; k < SLOTS; k++) begin
            if (slot_registered[(first + k) % SLOTS]) begin
               op.slot = SLOT_W'((first + k) % SLOTS);
            end
         end
      end
      return op;
   endfunction

   task automatic send_timer_op(input req_type op);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      compute_timer_reports(op);
      ops_sent++;
   endtask

   task automatic drain_reports(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (timer_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_ticks_per_ms(input logic [TPM_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rate_ticks_per_ms = value;
      rate_settings++;
   endtask

   task automatic set_idling(input int sender, input int receiver);
      idle_pct  = sender;
      stall_pct <= receiver;
   endtask

   task automatic run_random_phase(input int sender, input int receiver,
                                   input logic [TPM_W-1:0] rate);
      drain_reports(SETTLE_CYCLES);
      set_idling(sender, receiver);
      set_ticks_per_ms(rate);
      repeat (RANDOM_PHASE_OPS) begin
         if ($urandom_range(39) == 0) begin
            drain_reports(0);
         end
         send_timer_op(random_timer_op());
      end
   endtask

   task automatic test_operations();
      set_idling(0, 0);
      set_ticks_per_ms(TPM_W'(1));
      send_timer_op(make_op(OP_QUERY, 0, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_TICK, 0, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_REGISTER, 0, 1'b0, 1'b0, 16'hFFFF));
      send_timer_op(make_op(OP_START, 0, 1'b0, 1'b1, 16'd5));
      send_timer_op(make_op(OP_STOP, 7, 1'b1, 1'b1, '0));
      send_timer_op(make_op(OP_REMOVE, 3, 1'b0, 1'b1, '0));
      send_timer_op(make_op(OP_REGISTER, 0, 1'b0, 1'b1, '0));
      send_timer_op(make_op(OP_REGISTER, 0, 1'b1, 1'b1, '0));
      send_timer_op(make_op(OP_START, 0, 1'b0, 1'b1, '0));
      send_timer_op(make_op(OP_START, 0, 1'b0, 1'b1, 16'd2));
      send_timer_op(make_op(OP_REGISTER, 7, 1'b1, 1'b1, '0));
      send_timer_op(make_op(OP_START, 7, 1'b1, 1'b0, 16'd1));
      drain_reports(0);
      repeat (3) send_timer_op(make_op(OP_TICK, 0, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_QUERY, 0, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_STOP, 7, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_TICK, 7, 1'b1, 1'b1, 16'hFFFF));
      send_timer_op(make_op(OP_SPARE_A, 5, 1'b1, 1'b1, 16'hFFFF));
      send_timer_op(make_op(OP_SPARE_B, 7, 1'b1, 1'b1, 16'hFFFF));
      send_timer_op(make_op(OP_START, 7, 1'b1, 1'b1, 16'hFFFF));
      send_timer_op(make_op(OP_QUERY, 7, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_REMOVE, 7, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_REMOVE, 0, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_QUERY, 7, 1'b0, 1'b0, '0));
   endtask

   // With a zero rate every started periodic slot is due on each tick, so a
   // single tick produces an expiry transaction from all eight slots.
   task automatic test_rate_extremes();
      drain_reports(SETTLE_CYCLES);
      set_ticks_per_ms(TPM_W'(0));
      for (int s = 0; s < SLOTS; s++) begin
         send_timer_op(make_op(OP_REMOVE, s, 1'b0, 1'b0, '0));
      end
      for (int s = 0; s < SLOTS; s++) begin
         send_timer_op(make_op(OP_REGISTER, s, 1'b1, 1'b1, '0));
      end
      for (int s = 0; s < SLOTS; s++) begin
         send_timer_op(make_op(OP_START, s, 1'b0, 1'b0, MS_W'(s + 1)));
      end
      repeat (2) send_timer_op(make_op(OP_TICK, 0, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_REMOVE, 3, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_REGISTER, 3, 1'b0, 1'b1, '0));
      send_timer_op(make_op(OP_START, 3, 1'b0, 1'b0, 16'd9));
      send_timer_op(make_op(OP_TICK, 0, 1'b0, 1'b0, '0));
      drain_reports(SETTLE_CYCLES);
      set_ticks_per_ms(10'd1023);
      send_timer_op(make_op(OP_START, 2, 1'b0, 1'b0, 16'hFFFF));
      send_timer_op(make_op(OP_TICK, 0, 1'b0, 1'b0, '0));
      send_timer_op(make_op(OP_QUERY, 2, 1'b0, 1'b0, '0));
   endtask

   task automatic test_steady_traffic();
      run_random_phase(0, 0, 10'd1);
   endtask

   task automatic test_sender_gaps();
      run_random_phase(59, 0, 10'd1000);
   endtask

   task automatic test_receiver_stalls();
      run_random_phase(0, 59, 10'd2);
   endtask

   task automatic test_mixed_idling();
      run_random_phase(26, 26, 10'd1);
   endtask

   initial begin
      rate_ticks_per_ms = 10'd1;
      tick_count        = '0;
      slot_registered   = '0;
      slot_enabled      = '0;
      slot_periodic     = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_period[i]   = '0;
         slot_deadline[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operations();
      test_rate_extremes();
      test_steady_traffic();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      drain_reports(SETTLE_CYCLES);
      if (timer_reports.size() != 0) begin
         $display("%0d expected transactions never arrived", timer_reports.size());
         error_count += timer_reports.size();
      end
      $display("Sent %0d requests across %0d tick-rate settings and four idling mixes.",
               ops_sent, rate_settings);
      $display("Checked %0d result transactions, %0d of them expiries; %0d errors.",
               reports_checked, expiries_checked, error_count);
      if (error_count == 0) begin
         $display("soft_timer_bank_unit test passed");
      end else begin
         $display("soft_timer_bank_unit test failed");
      end
      $finish;
   end

endmodule
